// File: src/vrp_pkg.sv
// vrp_pkg: field widths, register codes, sine coefficients and pipeline depths
// shared by the vertex rotate/project unit and its submodules; no dependencies
package vrp_pkg;

  localparam int COORD_W   = 12;
  localparam int PHASE_W   = 12;
  localparam int OUT_W     = 16;
  localparam int FOCAL_W   = 12;
  localparam int CENTRE_W  = 10;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FOCAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 2'd2;

  localparam logic [FOCAL_W-1:0]  FOCAL_RESET  = 12'd250;
  localparam logic [CENTRE_W-1:0] CENTRE_RESET = 10'd120;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // taylor coefficients of sin(pi/2 t), q1.30
  localparam logic [30:0] SIN_C9 = 31'd172271;
  localparam logic [30:0] SIN_COEF [4] = '{31'd5026937, 31'd85569278,
                                           31'd693598671, 31'd1686629713};

  localparam int QUOT_BITS = 17;
  localparam int SIN_LAT   = 7;
  localparam int ROT_LAT   = 4;
  localparam int PROJ_LAT  = QUOT_BITS + 4;
  localparam int TOTAL_LAT = SIN_LAT + ROT_LAT + PROJ_LAT;

endpackage

// File: src/vrp_sine.sv
// vrp_sine: seven-stage sine evaluator for a 16-bit turn fraction, q1.FRAC_BITS
// horner evaluation of the taylor polynomial; uses vrp_pkg
module vrp_sine #(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic [15:0]                 phase,
  output logic signed [FRAC_BITS+1:0] sine
);

  localparam int TW = FRAC_BITS + 2;

  logic [1:0]  quad;
  logic [14:0] t_c;
  logic [29:0] tsq;

  logic [14:0] t_q  [5];
  logic [30:0] t2_q [4];
  logic [30:0] r_q  [4];
  logic        neg_q [6];
  logic [30:0] s_q;

  logic [61:0] s_prod;
  logic [31:0] rnd;
  logic [31:0] rs;
  logic [31:0] mag;

  assign quad = phase[15:14];
  assign t_c  = quad[0] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
  assign tsq  = t_c * t_c;

  always_ff @(posedge clk) begin
    t_q[0]   <= t_c;
    t2_q[0]  <= 31'({tsq, 2'b00});
    neg_q[0] <= quad[1];
    for (int i = 1; i < 5; i++) t_q[i] <= t_q[i-1];
    for (int i = 1; i < 4; i++) t2_q[i] <= t2_q[i-1];
    for (int i = 1; i < 6; i++) neg_q[i] <= neg_q[i-1];
  end

  for (genvar g = 0; g < 4; g++) begin : g_horner
    logic [30:0] rin;
    logic [61:0] prod;
    if (g == 0) begin : g_first
      assign rin = vrp_pkg::SIN_C9;
    end else begin : g_rest
      assign rin = r_q[g-1];
    end
    assign prod = t2_q[g] * rin;
    always_ff @(posedge clk) begin
      r_q[g] <= vrp_pkg::SIN_COEF[g] - 31'(prod >> 30);
    end
  end

  assign s_prod = {t_q[4], 16'b0} * r_q[3];

  always_ff @(posedge clk) begin
    s_q <= 31'(s_prod >> 30);
  end

  // round half up to the output precision, clamp to one
  assign rnd = 32'(s_q) + (32'd1 << (29 - FRAC_BITS));
  assign rs  = rnd >> (30 - FRAC_BITS);
  assign mag = (rs > (32'd1 << FRAC_BITS)) ? (32'd1 << FRAC_BITS) : rs;

  always_ff @(posedge clk) begin
    if (neg_q[5]) begin
      sine <= -$signed(TW'(mag));
    end else begin
      sine <= $signed(TW'(mag));
    end
  end

endmodule

// File: src/vrp_rotate.sv
// vrp_rotate: four-stage yaw then pitch rotation of an integer vertex
// takes sine/cosine in q1.FRAC_BITS; uses vrp_pkg
module vrp_rotate #(
  parameter int FRAC_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [vrp_pkg::COORD_W-1:0] x,
  input  logic signed [vrp_pkg::COORD_W-1:0] y,
  input  logic signed [vrp_pkg::COORD_W-1:0] z,
  input  logic signed [FRAC_BITS+1:0]    sx,
  input  logic signed [FRAC_BITS+1:0]    cx,
  input  logic signed [FRAC_BITS+1:0]    sy,
  input  logic signed [FRAC_BITS+1:0]    cy,
  output logic                           out_valid,
  output logic signed [2*FRAC_BITS+17:0] x2,
  output logic signed [2*FRAC_BITS+17:0] y2,
  output logic signed [2*FRAC_BITS+17:0] z2
);

  localparam int TW = FRAC_BITS + 2;
  localparam int PW = vrp_pkg::COORD_W + TW;
  localparam int RW = PW + 1;
  localparam int LW = RW + TW;
  localparam int QW = 2 * FRAC_BITS + 18;

  logic [vrp_pkg::ROT_LAT-1:0] v;

  logic signed [PW-1:0] p_xcy, p_zsy, p_xsy, p_zcy;
  logic signed [vrp_pkg::COORD_W-1:0] y_1, y_2;
  logic signed [TW-1:0] sx_1, cx_1, sx_2, cx_2;
  logic signed [RW-1:0] x1, z1, x1_3;
  logic signed [PW-1:0] ycx, ysx;
  logic signed [LW-1:0] z1sx, z1cx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[vrp_pkg::ROT_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    p_xcy <= PW'(x) * PW'(cy);
    p_zsy <= PW'(z) * PW'(sy);
    p_xsy <= PW'(x) * PW'(sy);
    p_zcy <= PW'(z) * PW'(cy);
    y_1   <= y;
    sx_1  <= sx;
    cx_1  <= cx;

    x1    <= RW'(p_xcy) + RW'(p_zsy);
    z1    <= RW'(p_zcy) - RW'(p_xsy);
    y_2   <= y_1;
    sx_2  <= sx_1;
    cx_2  <= cx_1;

    ycx   <= PW'(y_2) * PW'(cx_2);
    ysx   <= PW'(y_2) * PW'(sx_2);
    z1sx  <= LW'(z1) * LW'(sx_2);
    z1cx  <= LW'(z1) * LW'(cx_2);
    x1_3  <= x1;

    // everything lined up in q.2f
    y2    <= (QW'(ycx) <<< FRAC_BITS) - QW'(z1sx);
    z2    <= (QW'(ysx) <<< FRAC_BITS) + QW'(z1cx);
    x2    <= QW'(x1_3) <<< FRAC_BITS;
  end

  assign out_valid = v[vrp_pkg::ROT_LAT-1];

endmodule

// File: src/vrp_project.sv
// vrp_project: perspective divide, centre offset and saturation, one quotient
// bit per stage for both screen axes; uses vrp_pkg
module vrp_project #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [2*FRAC_BITS+17:0]        x2,
  input  logic signed [2*FRAC_BITS+17:0]        y2,
  input  logic signed [2*FRAC_BITS+17:0]        z2,
  input  logic [vrp_pkg::FOCAL_W-1:0]           focal,
  input  logic [vrp_pkg::CENTRE_W-1:0]          centre_x,
  input  logic [vrp_pkg::CENTRE_W-1:0]          centre_y,
  output logic                                  out_valid,
  output logic signed [vrp_pkg::OUT_W-1:0]      col,
  output logic signed [vrp_pkg::OUT_W-1:0]      row,
  output logic                                  behind
);

  localparam int QW  = 2 * FRAC_BITS + 18;
  localparam int NW  = QW + vrp_pkg::FOCAL_W + 1;
  localparam int QB  = vrp_pkg::QUOT_BITS;
  localparam int RMW = QW + QB;
  localparam int SW  = QB + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

  logic signed [NW-1:0] num1 [2];
  logic signed [QW:0]   den1;
  logic                 v1, v2;

  logic [NW-1:0] mag2 [2];
  logic [1:0]    neg2;
  logic [QW-1:0] den2;
  logic          behind2;

  // divider pipeline, index 0 is the stage after the overflow check
  logic [RMW-1:0] rem [QB+1][2];
  logic [QB-1:0]  quo [QB+1][2];
  logic [QW-1:0]  den_d [QB+1];
  logic [1:0]     neg_d [QB+1];
  logic [1:0]     ovf_d [QB+1];
  logic [QB:0]    behind_d;
  logic [QB:0]    v_d;

  logic [vrp_pkg::CENTRE_W-1:0] centre [2];
  logic signed [vrp_pkg::OUT_W-1:0] res [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v_d <= '0;
      out_valid <= 1'b0;
    end else begin
      v1  <= in_valid;
      v2  <= v1;
      v_d <= {v_d[QB-1:0], v2};
      out_valid <= v_d[QB];
    end
  end

  always_ff @(posedge clk) begin
    num1[0] <= NW'(x2) * NW'($signed({1'b0, focal}));
    num1[1] <= NW'(y2) * NW'($signed({1'b0, focal}));
    den1    <= $signed((QW+1)'(focal) << (2 * FRAC_BITS)) + (QW+1)'(z2);

    behind2 <= den1[QW] || (den1 == '0);
    den2    <= den1[QW-1:0];
    for (int l = 0; l < 2; l++) begin
      neg2[l] <= num1[l][NW-1];
      mag2[l] <= num1[l][NW-1] ? NW'(-num1[l]) : NW'(num1[l]);
    end

    // quotient of a magnitude this large saturates whatever the centre
    for (int l = 0; l < 2; l++) begin
      ovf_d[0][l] <= RMW'(mag2[l]) >= {den2, QB'(0)};
      rem[0][l]   <= RMW'(mag2[l]);
      quo[0][l]   <= '0;
    end
    neg_d[0]    <= neg2;
    den_d[0]    <= den2;
    behind_d[0] <= behind2;
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int B = QB - 1 - k;
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [RMW:0] trial;
      assign trial = {1'b0, rem[k][l]} - {1'b0, RMW'(den_d[k]) << B};
      always_ff @(posedge clk) begin
        if (trial[RMW]) begin
          rem[k+1][l] <= rem[k][l];
          quo[k+1][l] <= quo[k][l];
        end else begin
          rem[k+1][l] <= trial[RMW-1:0];
          quo[k+1][l] <= quo[k][l] | (QB'(1) << B);
        end
      end
    end
    always_ff @(posedge clk) begin
      den_d[k+1]    <= den_d[k];
      neg_d[k+1]    <= neg_d[k];
      ovf_d[k+1]    <= ovf_d[k];
      behind_d[k+1] <= behind_d[k];
    end
  end

  assign centre[0] = centre_x;
  assign centre[1] = centre_y;

  for (genvar l = 0; l < 2; l++) begin : g_out
    logic signed [QB:0]   q_s;
    logic signed [SW-1:0] sum;
    assign q_s = neg_d[QB][l] ? -$signed({1'b0, quo[QB][l]}) : $signed({1'b0, quo[QB][l]});
    assign sum = SW'(q_s) + SW'($signed({1'b0, centre[l]}));
    always_comb begin
      if (behind_d[QB]) begin
        res[l] = vrp_pkg::OUT_W'($signed({1'b0, centre[l]}));
      end else if (ovf_d[QB][l]) begin
        res[l] = neg_d[QB][l] ? 16'sh8000 : 16'sh7fff;
      end else if (sum > SAT_HI) begin
        res[l] = 16'sh7fff;
      end else if (sum < SAT_LO) begin
        res[l] = 16'sh8000;
      end else begin
        res[l] = vrp_pkg::OUT_W'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    col    <= res[0];
    row    <= res[1];
    behind <= behind_d[QB];
  end

endmodule

// File: src/vertex_rotate_project_unit.sv
// vertex_rotate_project_unit: top level, configuration registers and the
// sine, rotation and projection pipelines; uses vrp_pkg, vrp_sine, vrp_rotate, vrp_project

// One vertex request is taken in every clock cycle while start is high and busy
// is low; busy is high only during reset. Each request gives one result on
// screen_col, screen_row and behind_viewer, marked by done for a single cycle,
// after the request has passed through the sine/cosine evaluator, the rotation
// and the perspective stage, whose quotient pipeline gives one bit per stage.
// The receiver cannot hold results back and results come in request order.
// Configuration writes take effect at once and are meant for moments when no
// request is in flight.
module vertex_rotate_project_unit #(
  parameter int ANGLE_BITS     = 12,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vrp_pkg::COORD_W-1:0]    vert_x,
  input  logic signed [vrp_pkg::COORD_W-1:0]    vert_y,
  input  logic signed [vrp_pkg::COORD_W-1:0]    vert_z,
  input  logic [vrp_pkg::PHASE_W-1:0]           pitch_phase,
  input  logic [vrp_pkg::PHASE_W-1:0]           yaw_phase,
  input  logic                                  cfg_we,
  input  logic [vrp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [vrp_pkg::CFG_W-1:0]             cfg_data,
  output logic                                  done,
  output logic signed [vrp_pkg::OUT_W-1:0]      screen_col,
  output logic signed [vrp_pkg::OUT_W-1:0]      screen_row,
  output logic                                  behind_viewer
);

  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int QW = 2 * TRIG_FRAC_BITS + 18;
  localparam int SL = vrp_pkg::SIN_LAT;
  localparam logic [16:0] ANGLE_MASK = 17'((1 << ANGLE_BITS) - 1);

  logic [vrp_pkg::FOCAL_W-1:0]  focal_length;
  logic [vrp_pkg::CENTRE_W-1:0] center_x;
  logic [vrp_pkg::CENTRE_W-1:0] center_y;

  logic [15:0] ph_pitch, ph_yaw;
  logic signed [TW-1:0] sx, cx, sy, cy;

  logic signed [vrp_pkg::COORD_W-1:0] xd [SL];
  logic signed [vrp_pkg::COORD_W-1:0] yd [SL];
  logic signed [vrp_pkg::COORD_W-1:0] zd [SL];
  logic [SL-1:0] vd;

  logic rot_valid;
  logic signed [QW-1:0] x2, y2, z2;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_length <= vrp_pkg::FOCAL_RESET;
      center_x     <= vrp_pkg::CENTRE_RESET;
      center_y     <= vrp_pkg::CENTRE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vrp_pkg::REG_FOCAL:    focal_length <= cfg_data;
        vrp_pkg::REG_CENTRE_X: center_x     <= cfg_data[vrp_pkg::CENTRE_W-1:0];
        vrp_pkg::REG_CENTRE_Y: center_y     <= cfg_data[vrp_pkg::CENTRE_W-1:0];
        default: ;
      endcase
    end
  end

  // phase widened to a 16-bit turn fraction, upper bits wrap away
  assign ph_pitch = 16'(({5'b0, pitch_phase} & ANGLE_MASK) << (16 - ANGLE_BITS));
  assign ph_yaw   = 16'(({5'b0, yaw_phase} & ANGLE_MASK) << (16 - ANGLE_BITS));

  vrp_sine #(.FRAC_BITS(TRIG_FRAC_BITS)) u_sin_x (
    .clk(clk), .phase(ph_pitch), .sine(sx)
  );
  vrp_sine #(.FRAC_BITS(TRIG_FRAC_BITS)) u_cos_x (
    .clk(clk), .phase(16'(ph_pitch + vrp_pkg::QUARTER_TURN)), .sine(cx)
  );
  vrp_sine #(.FRAC_BITS(TRIG_FRAC_BITS)) u_sin_y (
    .clk(clk), .phase(ph_yaw), .sine(sy)
  );
  vrp_sine #(.FRAC_BITS(TRIG_FRAC_BITS)) u_cos_y (
    .clk(clk), .phase(16'(ph_yaw + vrp_pkg::QUARTER_TURN)), .sine(cy)
  );

  // vertex rides alongside the sine evaluators
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= '0;
    end else begin
      vd <= {vd[SL-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    xd[0] <= vert_x;
    yd[0] <= vert_y;
    zd[0] <= vert_z;
    for (int i = 1; i < SL; i++) begin
      xd[i] <= xd[i-1];
      yd[i] <= yd[i-1];
      zd[i] <= zd[i-1];
    end
  end

  vrp_rotate #(.FRAC_BITS(TRIG_FRAC_BITS)) u_rotate (
    .clk(clk), .rst(rst), .in_valid(vd[SL-1]),
    .x(xd[SL-1]), .y(yd[SL-1]), .z(zd[SL-1]),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy),
    .out_valid(rot_valid), .x2(x2), .y2(y2), .z2(z2)
  );

  vrp_project #(.FRAC_BITS(TRIG_FRAC_BITS)) u_project (
    .clk(clk), .rst(rst), .in_valid(rot_valid),
    .x2(x2), .y2(y2), .z2(z2),
    .focal(focal_length), .centre_x(center_x), .centre_y(center_y),
    .out_valid(done), .col(screen_col), .row(screen_row), .behind(behind_viewer)
  );

endmodule

// File: src/vrp_checker.sv
// vrp_checker: port-level checks on request timing and behind-viewer results
// bound to vertex_rotate_project_unit; uses vrp_pkg
module vrp_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic signed [vrp_pkg::OUT_W-1:0] screen_col,
  input logic signed [vrp_pkg::OUT_W-1:0] screen_row,
  input logic                             behind_viewer
);

  localparam int LAT = vrp_pkg::TOTAL_LAT;

  // every request taken comes out after the fixed latency
  a_request_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request taken but no result after pipeline latency");

  // no result without a request taken the latency before
  a_done_has_request: assert property (@(posedge clk)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching request");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // behind the viewer the centre comes back, always within the register range
  a_behind_centre: assert property (@(posedge clk) disable iff (rst)
    (done && behind_viewer) |->
      (screen_col >= 0 && screen_col <= 1023 && screen_row >= 0 && screen_row <= 1023))
    else $error("behind-viewer result is not a screen centre");

endmodule

bind vertex_rotate_project_unit vrp_checker u_vrp_checker (.*);

// File: tb/sv/tb_vertex_rotate_project_unit.sv
// tb_vertex_rotate_project_unit: self-checking bench for the vertex rotate/project unit
// with its own fixed-point predictor; depends on vrp_pkg and vertex_rotate_project_unit
module tb_vertex_rotate_project_unit;

  localparam int PIPE_CYCLES = 40;
  localparam int IDLE_LIMIT  = 4000;

  typedef struct {
    logic signed [vrp_pkg::OUT_W-1:0] col;
    logic signed [vrp_pkg::OUT_W-1:0] row;
    logic                             behind;
  } screen_point_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [vrp_pkg::COORD_W-1:0] vert_x, vert_y, vert_z;
  logic [vrp_pkg::PHASE_W-1:0] pitch_phase, yaw_phase;
  logic cfg_we;
  logic [vrp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [vrp_pkg::CFG_W-1:0] cfg_data;
  logic done;
  logic signed [vrp_pkg::OUT_W-1:0] screen_col, screen_row;
  logic behind_viewer;

  // local copy of the configuration registers
  logic [vrp_pkg::FOCAL_W-1:0]  focal_q;
  logic [vrp_pkg::CENTRE_W-1:0] cx_q, cy_q;

  screen_point_t expected_points[$];
  int errors;
  int sent;
  int checked;
  int behind_seen;

  vertex_rotate_project_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vert_x(vert_x), .vert_y(vert_y), .vert_z(vert_z),
    .pitch_phase(pitch_phase), .yaw_phase(yaw_phase),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .screen_col(screen_col), .screen_row(screen_row),
    .behind_viewer(behind_viewer)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sine of a 16-bit turn fraction in q1.14, taylor series by horner's rule
  function automatic longint sine_q14(input logic [15:0] ph);
    logic [1:0] quad;
    longint unsigned t, t30, t2, r, s;
    quad = ph[15:14];
    t = quad[0] ? (64'd16384 - ph[13:0]) : {50'd0, ph[13:0]};
    t30 = t << 16;
    t2 = (t * t) << 2;
    r = 64'd172271;
    r = 64'd5026937 - ((t2 * r) >> 30);
    r = 64'd85569278 - ((t2 * r) >> 30);
    r = 64'd693598671 - ((t2 * r) >> 30);
    r = 64'd1686629713 - ((t2 * r) >> 30);
    s = (t30 * r) >> 30;
    s = (s + 64'd32768) >> 16;
    if (s > 64'd16384) s = 64'd16384;
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic screen_point_t project_vertex(
    input logic signed [vrp_pkg::COORD_W-1:0] vx, vy, vz,
    input logic [vrp_pkg::PHASE_W-1:0] pp, yp
  );
    screen_point_t pt;
    logic [15:0] pw, yw;
    longint x, y, z, sx, cx, sy, cy, x1, z1, y2, z2, x2, f, den;
    pw = {pp, 4'd0};
    yw = {yp, 4'd0};
    x = vx; y = vy; z = vz;
    sx = sine_q14(pw);
    cx = sine_q14(pw + vrp_pkg::QUARTER_TURN);
    sy = sine_q14(yw);
    cy = sine_q14(yw + vrp_pkg::QUARTER_TURN);
    x1 = x * cy + z * sy;
    z1 = -x * sy + z * cy;
    y2 = y * cx * 16384 - z1 * sx;
    z2 = y * sx * 16384 + z1 * cx;
    x2 = x1 * 16384;
    f = longint'(focal_q);
    den = f * 64'sd268435456 + z2;
    if (den <= 0) begin
      pt.col = vrp_pkg::OUT_W'(cx_q);
      pt.row = vrp_pkg::OUT_W'(cy_q);
      pt.behind = 1'b1;
    end else begin
      pt.col = vrp_pkg::OUT_W'(clamp16((x2 * f) / den + longint'(cx_q)));
      pt.row = vrp_pkg::OUT_W'(clamp16((y2 * f) / den + longint'(cy_q)));
      pt.behind = 1'b0;
    end
    return pt;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // one request; gap idle cycles go before it
  task automatic send_vertex(input logic signed [vrp_pkg::COORD_W-1:0] vx, vy, vz,
                             input logic [vrp_pkg::PHASE_W-1:0] pp, yp, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    vert_x <= vx;
    vert_y <= vy;
    vert_z <= vz;
    pitch_phase <= pp;
    yaw_phase <= yp;
    do @(posedge clk); while (busy);
    expected_points.push_back(project_vertex(vx, vy, vz, pp, yp));
    sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [vrp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vrp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      vrp_pkg::REG_FOCAL:    focal_q = val[vrp_pkg::FOCAL_W-1:0];
      vrp_pkg::REG_CENTRE_X: cx_q = val[vrp_pkg::CENTRE_W-1:0];
      vrp_pkg::REG_CENTRE_Y: cy_q = val[vrp_pkg::CENTRE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(input logic [vrp_pkg::CFG_W-1:0] f,
                          input logic [vrp_pkg::CFG_W-1:0] cx,
                          input logic [vrp_pkg::CFG_W-1:0] cy);
    drain_pipeline();
    write_reg(vrp_pkg::REG_FOCAL, f);
    write_reg(vrp_pkg::REG_CENTRE_X, cx);
    write_reg(vrp_pkg::REG_CENTRE_Y, cy);
  endtask

  function automatic int random_gap(input bit allow_idle);
    if (!allow_idle || $urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 7);
  endfunction

  // extremes, quadrant phases, the depth plane and saturation, at reset values
  task automatic test_directed();
    send_vertex(0, 0, 0, 0, 0, 0);
    send_vertex(2047, 2047, 2047, 0, 0, 0);
    send_vertex(-2048, -2048, 0, 0, 0, 1);
    send_vertex(100, -100, 50, 1024, 0, 0);
    send_vertex(100, -100, 50, 2048, 1024, 0);
    send_vertex(100, -100, 50, 3072, 2048, 2);
    send_vertex(100, -100, 50, 4095, 3072, 0);
    send_vertex(-300, 200, 75, 512, 4095, 0);
    send_vertex(10, 10, -250, 0, 0, 0);     // depth exactly on the focal plane
    send_vertex(10, 10, -2048, 0, 0, 0);    // far behind the viewer
    send_vertex(2047, 2047, -249, 0, 0, 0); // saturate high
    send_vertex(-2048, -2048, -249, 0, 0, 0); // saturate low
    send_vertex(0, 2047, 0, 3072, 0, 0);    // pitch pushes y into depth
    send_vertex(2047, 0, 0, 0, 1024, 3);    // yaw pushes x into depth
    send_vertex(-2048, 0, 0, 0, 1024, 0);
    send_vertex(5, 7, 1, 1, 4094, 0);
  endtask

  // every register at its extremes, masked upper data bits and the unused index
  task automatic test_registers();
    set_view(12'd1, 12'd0, 12'd1023);
    send_vertex(2047, -2048, 0, 0, 0, 0);
    send_vertex(3, 3, -1, 0, 0, 0);
    send_vertex(100, 100, 2047, 256, 256, 0);
    set_view(12'd4095, 12'hFFF, 12'hC00); // centre writes keep only ten bits
    send_vertex(2047, 2047, -2048, 0, 0, 0);
    send_vertex(-2048, 2047, 1000, 1500, 3000, 0);
    drain_pipeline();
    write_reg(2'd3, 12'd7);
    send_vertex(50, 60, 70, 100, 200, 0);
    set_view(12'd0, 12'd512, 12'd300); // zero focal is taken as written
    send_vertex(100, 100, 100, 0, 0, 0);
    send_vertex(100, 100, -100, 0, 0, 0);
    send_vertex(100, 100, 0, 0, 0, 0);
  endtask

  task automatic send_random_vertex(input bit allow_idle);
    logic signed [vrp_pkg::COORD_W-1:0] vx, vy, vz;
    logic [vrp_pkg::PHASE_W-1:0] pp, yp;
    int kind;
    kind = $urandom_range(0, 9);
    vx = vrp_pkg::COORD_W'($urandom);
    vy = vrp_pkg::COORD_W'($urandom);
    vz = vrp_pkg::COORD_W'($urandom);
    pp = vrp_pkg::PHASE_W'($urandom);
    yp = vrp_pkg::PHASE_W'($urandom);
    if (kind < 3) begin
      // small vertices around the focal plane, small angles
      vx = vrp_pkg::COORD_W'($signed(vrp_pkg::COORD_W'($urandom_range(0, 255))) - 128);
      vy = vrp_pkg::COORD_W'($signed(vrp_pkg::COORD_W'($urandom_range(0, 255))) - 128);
      vz = vrp_pkg::COORD_W'(-$signed({1'b0, focal_q[vrp_pkg::COORD_W-2:0]})
             + $signed(vrp_pkg::COORD_W'($urandom_range(0, 8))) - 4);
      pp = $urandom_range(0, 3) == 0 ? vrp_pkg::PHASE_W'($urandom_range(0, 8)) : '0;
      yp = $urandom_range(0, 3) == 0 ? vrp_pkg::PHASE_W'(4096 - $urandom_range(0, 8)) : '0;
    end else if (kind == 3) begin
      pp = vrp_pkg::PHASE_W'($urandom_range(0, 3) * 1024);
      yp = vrp_pkg::PHASE_W'($urandom_range(0, 3) * 1024);
    end
    send_vertex(vx, vy, vz, pp, yp, random_gap(allow_idle));
  endtask

  task automatic test_random_views();
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: set_view(12'd250, 12'd120, 12'd120);
        1: set_view(12'd1, 12'd1023, 12'd0);
        2: set_view(12'd4095, 12'd0, 12'd1023);
        default: set_view(12'($urandom_range(1, 4095)), 12'($urandom), 12'($urandom));
      endcase
      repeat (150) send_random_vertex(1'b1);
      if (seg == 3) drain_pipeline();
    end
  endtask

  task automatic test_back_to_back();
    set_view(12'($urandom_range(100, 2000)), 12'($urandom_range(0, 1023)),
             12'($urandom_range(0, 1023)));
    repeat (200) send_random_vertex(1'b0);
  endtask

  // result checker
  initial begin
    screen_point_t e;
    forever begin
      @(posedge clk);
      if (!rst && done) begin
        if (expected_points.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          e = expected_points.pop_front();
          checked++;
          if (e.behind) behind_seen++;
          if (screen_col !== e.col)
            report_mismatch($sformatf("screen_col %0d, want %0d", screen_col, e.col));
          if (screen_row !== e.row)
            report_mismatch($sformatf("screen_row %0d, want %0d", screen_row, e.row));
          if (behind_viewer !== e.behind)
            report_mismatch($sformatf("behind_viewer %0b, want %0b", behind_viewer, e.behind));
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (start && !busy) || done || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog expired at %0t", $time);
        $display("[vertex_rotate_project_unit] ERROR");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; sent = 0; checked = 0; behind_seen = 0;
    start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    vert_x = '0; vert_y = '0; vert_z = '0; pitch_phase = '0; yaw_phase = '0;
    focal_q = vrp_pkg::FOCAL_RESET;
    cx_q = vrp_pkg::CENTRE_RESET;
    cy_q = vrp_pkg::CENTRE_RESET;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_registers();
    test_random_views();
    test_back_to_back();
    drain_pipeline();
    $display("sent %0d vertices, checked %0d results, %0d behind the viewer",
             sent, checked, behind_seen);
    $display("covered register extremes, zero focal, saturation and back-to-back requests");
    if (errors == 0) begin
      $display("[vertex_rotate_project_unit] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[vertex_rotate_project_unit] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/vrp_pkg.sv
src/vrp_sine.sv
src/vrp_rotate.sv
src/vrp_project.sv
src/vertex_rotate_project_unit.sv
src/vrp_checker.sv
tb/sv/tb_vertex_rotate_project_unit.sv
